// File: hw/rtl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared widths, register map, reset values and types for the beam peak
// detector.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned FRAC_W      = 9;
    localparam int unsigned BIN_FIELD_W = 11;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned REG_IDX_W   = 2;

    localparam int unsigned MAX_BINS_DEFAULT = 2048;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_MIN_HEIGHT         = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_END_FRACTION       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_FRACTION = 2'd2;

    localparam logic [SAMPLE_W-1:0] MIN_HEIGHT_RST         = 16'd110;
    localparam logic [FRAC_W-1:0]   END_FRACTION_RST       = 9'd154;
    localparam logic [FRAC_W-1:0]   THRESHOLD_FRACTION_RST = 9'd251;

    typedef struct packed {
        logic [SAMPLE_W-1:0] min_height;
        logic [FRAC_W-1:0]   end_fraction;
        logic [FRAC_W-1:0]   threshold_fraction;
    } bpd_cfg_t;

endpackage

// File: hw/rtl/bpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpd_cfg_regs
// APB register file holding min_height, end_fraction and threshold_fraction.
// ----------------------------------------------------------------------------
module bpd_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bpd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output bpd_pkg::bpd_cfg_t                   cfg
);
    import bpd_pkg::*;

    bpd_cfg_t             cfg_reg;
    bpd_cfg_t             cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_HEIGHT:         cfg_next.min_height = pwdata[SAMPLE_W-1:0];
                REG_END_FRACTION:       cfg_next.end_fraction = pwdata[FRAC_W-1:0];
                REG_THRESHOLD_FRACTION: cfg_next.threshold_fraction = pwdata[FRAC_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_HEIGHT:         prdata = APB_DATA_W'(cfg_reg.min_height);
            REG_END_FRACTION:       prdata = APB_DATA_W'(cfg_reg.end_fraction);
            REG_THRESHOLD_FRACTION: prdata = APB_DATA_W'(cfg_reg.threshold_fraction);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_height         <= MIN_HEIGHT_RST;
            cfg_reg.end_fraction       <= END_FRACTION_RST;
            cfg_reg.threshold_fraction <= THRESHOLD_FRACTION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/bpd_track.sv
// ----------------------------------------------------------------------------
// bpd_track
// Input register, valley/peak tracking state and result register. While no
// report stalls, one sample per cycle is evaluated against valley and maximum.
// ----------------------------------------------------------------------------
module bpd_track #(
    parameter int unsigned MAX_BINS = bpd_pkg::MAX_BINS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bpd_pkg::bpd_cfg_t                   cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpd_pkg::SAMPLE_W-1:0]        intensity,
    input  logic                                beam_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bpd_pkg::BIN_FIELD_W-1:0]     valley_bin,
    output logic [bpd_pkg::BIN_FIELD_W-1:0]     peak_bin,
    output logic [bpd_pkg::SAMPLE_W-1:0]        peak_level,
    output logic [bpd_pkg::BIN_FIELD_W-1:0]     end_bin,
    output logic [bpd_pkg::SAMPLE_W-1:0]        segment_threshold
);
    import bpd_pkg::*;

    localparam int unsigned BIN_W  = $clog2(MAX_BINS);
    localparam int unsigned PROD_W = SAMPLE_W + FRAC_W;
    localparam int unsigned THR_W  = SAMPLE_W + 2;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_BINS - 1);

    // input stage
    logic                in_vld_reg;
    logic                in_vld_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                start_reg;

    // tracking state
    logic                valley_valid_reg;
    logic [SAMPLE_W-1:0] valley_level_reg;
    logic [SAMPLE_W-1:0] valley_level_next;
    logic [BIN_W-1:0]    valley_index_reg;
    logic [BIN_W-1:0]    valley_index_next;
    logic [SAMPLE_W-1:0] peak_max_reg;
    logic [SAMPLE_W-1:0] peak_max_next;
    logic [BIN_W-1:0]    peak_index_reg;
    logic [BIN_W-1:0]    peak_index_next;
    logic [BIN_W-1:0]    bin_cnt_reg;
    logic [BIN_W-1:0]    bin_cnt_next;

    // result stage
    logic                   out_vld_reg;
    logic                   out_vld_next;
    logic [BIN_FIELD_W-1:0] valley_bin_reg;
    logic [BIN_FIELD_W-1:0] peak_bin_reg;
    logic [SAMPLE_W-1:0]    peak_level_reg;
    logic [BIN_FIELD_W-1:0] end_bin_reg;
    logic [SAMPLE_W-1:0]    seg_thr_reg;
    logic [SAMPLE_W-1:0]    seg_thr_next;

    // datapath
    logic                accept;
    logic                advance;
    logic                eff_valid;
    logic [SAMPLE_W-1:0] eff_valley;
    logic [BIN_W-1:0]    eff_vidx;
    logic [SAMPLE_W-1:0] eff_max;
    logic [BIN_W-1:0]    eff_pidx;
    logic [BIN_W-1:0]    bin;
    logic                take_valley;
    logic                take_max;
    logic                have_peak;
    logic                ended;
    logic                report;
    logic [SAMPLE_W-1:0] height;
    logic [SAMPLE_W-1:0] rise;
    logic [PROD_W-1:0]   end_lhs;
    logic [PROD_W-1:0]   end_rhs;
    logic [PROD_W-1:0]   thr_prod;
    logic [THR_W-1:0]    thr_sum;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        eff_valid  = start_reg ? 1'b0 : valley_valid_reg;
        eff_valley = start_reg ? '0 : valley_level_reg;
        eff_vidx   = start_reg ? '0 : valley_index_reg;
        eff_max    = start_reg ? '0 : peak_max_reg;
        eff_pidx   = start_reg ? '0 : peak_index_reg;
        bin        = start_reg ? '0 : bin_cnt_reg;
        bin_cnt_next = (bin == LAST_BIN) ? LAST_BIN : bin + BIN_W'(1);

        take_valley = !eff_valid || (sample_reg < eff_valley);
        take_max    = !take_valley && (sample_reg > eff_max);
        have_peak   = !take_valley && !take_max && (eff_max > eff_valley);

        height   = eff_max - eff_valley;
        rise     = sample_reg - eff_valley;
        end_lhs  = PROD_W'({rise, 8'd0});
        end_rhs  = PROD_W'(height) * PROD_W'(cfg.end_fraction);
        thr_prod = PROD_W'(height) * PROD_W'(cfg.threshold_fraction);
        thr_sum  = THR_W'(eff_valley) + THR_W'(thr_prod[PROD_W-1:8]);
        seg_thr_next = (thr_sum[THR_W-1:SAMPLE_W] != '0) ? '1 : thr_sum[SAMPLE_W-1:0];

        ended  = have_peak && (end_lhs < end_rhs);
        report = ended && (height > cfg.min_height);

        valley_level_next = (take_valley || ended) ? sample_reg : eff_valley;
        valley_index_next = (take_valley || ended) ? bin : eff_vidx;
        peak_max_next     = take_max ? sample_reg : (ended ? '0 : eff_max);
        peak_index_next   = take_max ? bin : eff_pidx;

        in_vld_next = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        if (advance)
            out_vld_next = report;
        else if (out_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            valley_valid_reg <= 1'b0;
            valley_level_reg <= '0;
            valley_index_reg <= '0;
            peak_max_reg     <= '0;
            peak_index_reg   <= '0;
            bin_cnt_reg      <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                valley_valid_reg <= 1'b1;
                valley_level_reg <= valley_level_next;
                valley_index_reg <= valley_index_next;
                peak_max_reg     <= peak_max_next;
                peak_index_reg   <= peak_index_next;
                bin_cnt_reg      <= bin_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= intensity;
            start_reg  <= beam_start;
        end
        if (advance && report)
        begin
            valley_bin_reg <= BIN_FIELD_W'(eff_vidx);
            peak_bin_reg   <= BIN_FIELD_W'(eff_pidx);
            peak_level_reg <= eff_max;
            end_bin_reg    <= BIN_FIELD_W'(bin);
            seg_thr_reg    <= seg_thr_next;
        end
    end

    assign out_valid         = out_vld_reg;
    assign valley_bin        = valley_bin_reg;
    assign peak_bin          = peak_bin_reg;
    assign peak_level        = peak_level_reg;
    assign end_bin           = end_bin_reg;
    assign segment_threshold = seg_thr_reg;

    // a cleared maximum is zero; otherwise it never sits below the valley
    a_max_above_valley: assert property (@(posedge clk) disable iff (!rst_n)
        valley_valid_reg |-> (peak_max_reg == '0) || (peak_max_reg >= valley_level_reg))
        else $error("peak maximum below valley");

    a_bin_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        bin_cnt_reg <= LAST_BIN)
        else $error("bin counter beyond last bin");

    a_report_clears_max: assert property (@(posedge clk) disable iff (!rst_n)
        advance && report |=> out_vld_reg && (peak_max_reg == '0)
            && (valley_level_reg == $past(sample_reg)))
        else $error("reported peak did not restart tracking");

    a_beat_taken_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !out_vld_reg |-> in_ready)
        else $error("input stalled with empty result stage");

endmodule

// File: hw/rtl/beam_peak_detector.sv
// ----------------------------------------------------------------------------
// beam_peak_detector
// Sonar beam peak finder: tracks valley and maximum along a beam and
// reports each ended peak taller than min_height.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready) carry one intensity sample and a
//   beam_start flag that restarts tracking at bin 0. Output beats
//   (out_valid/out_ready) carry one peak report: valley bin, peak bin,
//   peak level, end bin and segment threshold. Most samples give no beat.
//   Throughput is one sample per cycle unless a pending report stalls it,
//   set by the single evaluation stage between the input register and the
//   result register; a report is registered as its ending sample advances.
//   When the receiver stalls with a report pending, one more sample is
//   held in the input register, then in_ready drops until the report is
//   taken.
//   Reset empties both stages, clears tracking and the bin counter, and
//   loads min_height 110, end_fraction 154, threshold_fraction 251.
//   Registers sit at byte addresses 0, 4 and 8 on the APB port; write
//   them only while no beat is in flight.
// ----------------------------------------------------------------------------
module beam_peak_detector #(
    parameter int unsigned MAX_BINS = bpd_pkg::MAX_BINS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bpd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpd_pkg::SAMPLE_W-1:0]        intensity,
    input  logic                                beam_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bpd_pkg::BIN_FIELD_W-1:0]     valley_bin,
    output logic [bpd_pkg::BIN_FIELD_W-1:0]     peak_bin,
    output logic [bpd_pkg::SAMPLE_W-1:0]        peak_level,
    output logic [bpd_pkg::BIN_FIELD_W-1:0]     end_bin,
    output logic [bpd_pkg::SAMPLE_W-1:0]        segment_threshold
);
    import bpd_pkg::*;

    bpd_cfg_t cfg;

    bpd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpd_track #(
        .MAX_BINS (MAX_BINS)
    ) u_track (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .intensity         (intensity),
        .beam_start        (beam_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .valley_bin        (valley_bin),
        .peak_bin          (peak_bin),
        .peak_level        (peak_level),
        .end_bin           (end_bin),
        .segment_threshold (segment_threshold)
    );

endmodule

// File: dv/tb_beam_peak_detector.sv
// ----------------------------------------------------------------------------
// tb_beam_peak_detector
// Self-checking bench for the sonar beam peak detector. A scoreboard class
// tracks valley, maximum and bin position per sample and queues the expected
// peak reports. Directed beams cover the level extremes and the height and
// end-test boundaries. Shaped random beams follow, with several register
// settings, one long beam sent without gaps, and random gaps on both beat
// channels.
// ----------------------------------------------------------------------------
module tb_beam_peak_detector;

    timeunit 1ns;
    timeprecision 1ps;

    import bpd_pkg::*;

    localparam int unsigned BIN_LAST    = MAX_BINS_DEFAULT - 1;
    localparam int unsigned CYCLE_LIMIT = 500_000;

    typedef struct {
        logic [BIN_FIELD_W-1:0] valley_bin;
        logic [BIN_FIELD_W-1:0] peak_bin;
        logic [SAMPLE_W-1:0]    peak_level;
        logic [BIN_FIELD_W-1:0] end_bin;
        logic [SAMPLE_W-1:0]    segment_threshold;
    } peak_report_t;

    class peak_scoreboard;
        logic [SAMPLE_W-1:0] min_height;
        logic [FRAC_W-1:0]   end_frac;
        logic [FRAC_W-1:0]   thr_frac;
        logic [SAMPLE_W-1:0] valley_lvl;
        logic [SAMPLE_W-1:0] max_lvl;
        bit                  valley_seen;
        int unsigned         valley_pos;
        int unsigned         peak_pos;
        int unsigned         next_bin;
        peak_report_t        pending_reports[$];
        int                  errors;

        function new();
            min_height  = MIN_HEIGHT_RST;
            end_frac    = END_FRACTION_RST;
            thr_frac    = THRESHOLD_FRACTION_RST;
            valley_lvl  = '0;
            max_lvl     = '0;
            valley_seen = 1'b0;
            valley_pos  = 0;
            peak_pos    = 0;
            next_bin    = 0;
            errors      = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_MIN_HEIGHT:         min_height = data[SAMPLE_W-1:0];
                REG_END_FRACTION:       end_frac   = data[FRAC_W-1:0];
                REG_THRESHOLD_FRACTION: thr_frac   = data[FRAC_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return pending_reports.size();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] level, logic first);
            int unsigned       bin;
            int unsigned       height;
            int unsigned       rise;
            longint unsigned   lhs;
            longint unsigned   rhs;
            longint unsigned   thr;
            peak_report_t      rep;
            if (first)
            begin
                valley_lvl  = '0;
                valley_seen = 1'b0;
                max_lvl     = '0;
                valley_pos  = 0;
                peak_pos    = 0;
                bin         = 0;
            end
            else
            begin
                bin = next_bin;
            end
            if (bin > BIN_LAST)
                bin = BIN_LAST;
            next_bin = (bin >= BIN_LAST) ? BIN_LAST : bin + 1;

            if (!valley_seen || level < valley_lvl)
            begin
                valley_lvl  = level;
                valley_pos  = bin;
                valley_seen = 1'b1;
            end
            else if (level > max_lvl)
            begin
                max_lvl  = level;
                peak_pos = bin;
            end
            else if (max_lvl > valley_lvl)
            begin
                height = max_lvl - valley_lvl;
                rise   = level - valley_lvl;
                lhs    = longint'(rise) * 256;
                rhs    = longint'(height) * end_frac;
                if (lhs < rhs)
                begin
                    if (height > min_height)
                    begin
                        thr = valley_lvl + ((longint'(height) * thr_frac) >> 8);
                        if (thr > 65535)
                            thr = 65535;
                        rep.valley_bin        = BIN_FIELD_W'(valley_pos);
                        rep.peak_bin          = BIN_FIELD_W'(peak_pos);
                        rep.peak_level        = max_lvl;
                        rep.end_bin           = BIN_FIELD_W'(bin);
                        rep.segment_threshold = SAMPLE_W'(thr);
                        pending_reports = {pending_reports, rep};
                    end
                    valley_lvl = level;
                    valley_pos = bin;
                    max_lvl    = '0;
                end
            end
        endfunction

        function void cmp_field(string name, logic [SAMPLE_W-1:0] exp_v, logic [SAMPLE_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_report(peak_report_t got);
            peak_report_t want;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected report beat: valley_bin %0d peak_bin %0d end_bin %0d",
                       got.valley_bin, got.peak_bin, got.end_bin);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            cmp_field("valley_bin", want.valley_bin, got.valley_bin);
            cmp_field("peak_bin", want.peak_bin, got.peak_bin);
            cmp_field("peak_level", want.peak_level, got.peak_level);
            cmp_field("end_bin", want.end_bin, got.end_bin);
            cmp_field("segment_threshold", want.segment_threshold, got.segment_threshold);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic [SAMPLE_W-1:0]     intensity;
    logic                    beam_start;
    logic                    out_valid;
    logic                    out_ready;
    logic [BIN_FIELD_W-1:0]  valley_bin;
    logic [BIN_FIELD_W-1:0]  peak_bin;
    logic [SAMPLE_W-1:0]     peak_level;
    logic [BIN_FIELD_W-1:0]  end_bin;
    logic [SAMPLE_W-1:0]     segment_threshold;

    peak_scoreboard sb = new();
    bit             steady;
    int unsigned    cycles;

    beam_peak_detector u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .intensity         (intensity),
        .beam_start        (beam_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .valley_bin        (valley_bin),
        .peak_bin          (peak_bin),
        .peak_level        (peak_level),
        .end_bin           (end_bin),
        .segment_threshold (segment_threshold)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_beam_peak_detector: errors");
            $finish;
        end
    end

    // report sink: random stall before each beat, none while steady
    initial
    begin : report_sink
        int unsigned  stall;
        peak_report_t got;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.valley_bin        = valley_bin;
            got.peak_bin          = peak_bin;
            got.peak_level        = peak_level;
            got.end_bin           = end_bin;
            got.segment_threshold = segment_threshold;
            sb.check_report(got);
        end
    end

    // valid is only lowered ahead of a gap, so back-to-back beats keep it high
    task automatic send_sample(logic [SAMPLE_W-1:0] level, logic first);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        intensity  <= level;
        beam_start <= first;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(level, first);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, data);
    endtask

    task automatic configure(logic [SAMPLE_W-1:0] mh, logic [FRAC_W-1:0] ef,
                             logic [FRAC_W-1:0] tf);
        logic [APB_DATA_W-1:0] junk;
        drain();
        junk = $urandom_range(0, 1) ? $urandom : '0;
        write_reg(REG_MIN_HEIGHT, {junk[APB_DATA_W-1:SAMPLE_W], mh});
        write_reg(REG_END_FRACTION, {junk[APB_DATA_W-1:FRAC_W], ef});
        write_reg(REG_THRESHOLD_FRACTION, {junk[APB_DATA_W-1:FRAC_W], tf});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // bumps: rise from a random base to a top, fall to a random low; some noise
    task automatic build_beam(int unsigned len, output logic [SAMPLE_W-1:0] lv[$]);
        int unsigned base;
        int unsigned h;
        int unsigned top;
        int unsigned low;
        int unsigned rise;
        int unsigned fall;
        lv = {};
        while (lv.size() < len)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                lv = {lv, SAMPLE_W'($urandom)};
            end
            else
            begin
                base = $urandom_range(0, 65535);
                case ($urandom_range(0, 2))
                    0:       h = $urandom_range(0, 255);
                    1:       h = $urandom_range(0, 4000);
                    default: h = $urandom_range(0, 65535);
                endcase
                top  = (base + h > 65535) ? 65535 : base + h;
                low  = $urandom_range(0, top);
                rise = $urandom_range(1, 5);
                fall = $urandom_range(1, 5);
                lv = {lv, SAMPLE_W'(base)};
                for (int k = 1; k <= rise; k++)
                    lv = {lv, SAMPLE_W'(base + (top - base) * k / rise)};
                for (int k = 1; k <= fall; k++)
                    lv = {lv, SAMPLE_W'(top - (top - low) * k / fall)};
            end
        end
    endtask

    task automatic run_beams(int unsigned count);
        int unsigned         sent;
        logic [SAMPLE_W-1:0] lv[$];
        logic                first;
        sent = 0;
        while (sent < count)
        begin
            steady = ($urandom_range(0, 3) == 0);
            build_beam($urandom_range(4, 40), lv);
            foreach (lv[k])
            begin
                first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                send_sample(lv[k], first);
            end
            sent += lv.size();
        end
    endtask

    task automatic run_directed();
        logic [SAMPLE_W:0] seq[] = '{
            {1'b1, 16'd0},     {1'b0, 16'd65535}, {1'b0, 16'd65535}, {1'b0, 16'd0},
            {1'b0, 16'd100},   {1'b0, 16'd0},     {1'b1, 16'd500},   {1'b0, 16'd400},
            {1'b0, 16'd1000},  {1'b0, 16'd1000},  {1'b0, 16'd700},   {1'b0, 16'd0},
            {1'b0, 16'd0},     {1'b1, 16'd0},     {1'b0, 16'd110},   {1'b0, 16'd0},
            {1'b0, 16'd111},   {1'b0, 16'd0},     {1'b0, 16'd65535}, {1'b0, 16'd39424},
            {1'b0, 16'd39423}
        };
        steady = 1'b0;
        foreach (seq[k])
            send_sample(seq[k][SAMPLE_W-1:0], seq[k][SAMPLE_W]);
    endtask

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] lv[$];
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        intensity  = '0;
        beam_start = 1'b0;
        steady     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        configure(16'd0, 9'd256, 9'd256);
        run_beams(140);
        configure(16'hFFFF, 9'd0, 9'd511);
        run_beams(50);
        configure(16'd110, 9'd511, 9'd511);
        run_beams(140);

        // one long beam, no gaps
        configure(16'd50, 9'd154, 9'd251);
        steady = 1'b1;
        build_beam(250, lv);
        foreach (lv[k])
            send_sample(lv[k], k == 0);

        repeat (4)
        begin
            configure(SAMPLE_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 1500)),
                      FRAC_W'($urandom_range(0, 511)), FRAC_W'($urandom_range(0, 511)));
            run_beams(80);
        end
        configure(MIN_HEIGHT_RST, END_FRACTION_RST, THRESHOLD_FRACTION_RST);
        run_beams(100);

        drain();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_beam_peak_detector: clean");
        else
            $display("tb_beam_peak_detector: errors");
        $finish;
    end

endmodule
